@@ rtl/lav_pkg.sv @@
// shared types and constants of the look-at view matrix core
// used by every module in rtl, depends on nothing
package lav_pkg;

    localparam int AXIS_W = 32;               // q16.16 inputs, q2.30 axes
    localparam int WIDE_W = 64;               // exact products
    localparam int MAG_W  = 30;               // normalized magnitude bits
    localparam int SUM_W  = 62;               // sum of three squares
    localparam int ROOT_W = 31;               // floor square root bits
    localparam int QUO_W  = 31;               // quotient bits, at most one in q2.30
    localparam int FRAC_W = 30;               // fraction bits of the axes
    localparam int TOP_BIT = 29;              // largest magnitude ends up in [2^29, 2^30)

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_UP_X = 2'd0;
    localparam logic [1:0] REG_UP_Y = 2'd1;
    localparam logic [1:0] REG_UP_Z = 2'd2;

    localparam logic [31:0] UP_X_RST = 32'h0000_0000;
    localparam logic [31:0] UP_Y_RST = 32'h0001_0000;
    localparam logic [31:0] UP_Z_RST = 32'h0000_0000;

    typedef logic signed [AXIS_W-1:0] q_t;
    typedef logic signed [WIDE_W-1:0] w_t;
    typedef q_t [2:0] qvec_t;
    typedef w_t [2:0] wvec_t;
    typedef qvec_t [2:0] qmat_t;              // [0] right, [1] upward, [2] back

endpackage

@@ rtl/lav_norm.sv @@
// pipelined vector normalizer: leading-one search, shift, squares,
// bit-per-stage square root and three bit-per-stage dividers; uses lav_pkg
module lav_norm #(
    parameter int SB_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  lav_pkg::wvec_t      in_vec,
    input  logic [SB_W-1:0]     in_sb,
    output logic                out_valid,
    output lav_pkg::qvec_t      out_vec,
    output logic [SB_W-1:0]     out_sb
);

    localparam int MAG_W  = lav_pkg::MAG_W;
    localparam int SUM_W  = lav_pkg::SUM_W;
    localparam int ROOT_W = lav_pkg::ROOT_W;
    localparam int QUO_W  = lav_pkg::QUO_W;
    localparam int WIDE_W = lav_pkg::WIDE_W;

    // stage 0: sign and magnitude
    logic                       v0_reg;
    logic [2:0]                 neg0_reg;
    logic [2:0][WIDE_W-1:0]     mag0_reg;
    logic [SB_W-1:0]            sb0_reg;
    // stage 1: per-byte leading one
    logic                       v1_reg;
    logic [2:0]                 neg1_reg;
    logic [2:0][WIDE_W-1:0]     mag1_reg;
    logic [SB_W-1:0]            sb1_reg;
    logic [7:0]                 nz1_reg;
    logic [7:0][2:0]            pos1_reg;
    logic [7:0]                 nz1_next;
    logic [7:0][2:0]            pos1_next;
    // stage 2: leading one of the largest magnitude
    logic                       v2_reg;
    logic [2:0]                 neg2_reg;
    logic [2:0][WIDE_W-1:0]     mag2_reg;
    logic [SB_W-1:0]            sb2_reg;
    logic [5:0]                 p2_reg;
    logic                       zero2_reg;
    logic [5:0]                 p2_next;
    // stage 3: scaled magnitudes
    logic                       v3_reg;
    logic [2:0]                 neg3_reg;
    logic [2:0][MAG_W-1:0]      mag3_reg;
    logic [SB_W-1:0]            sb3_reg;
    logic                       zero3_reg;
    logic [2:0][MAG_W-1:0]      mag3_next;
    // stage 4: squares
    logic                       v4_reg;
    logic [2:0]                 neg4_reg;
    logic [2:0][MAG_W-1:0]      mag4_reg;
    logic [SB_W-1:0]            sb4_reg;
    logic                       zero4_reg;
    logic [2:0][2*MAG_W-1:0]    sqr4_reg;

    // square root stages, index 0 is the sum of squares
    logic                       sq_v    [ROOT_W+1];
    logic [SUM_W-1:0]           sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]          sq_root [ROOT_W+1];
    logic [2:0][MAG_W-1:0]      sq_mag  [ROOT_W+1];
    logic [2:0]                 sq_neg  [ROOT_W+1];
    logic                       sq_zero [ROOT_W+1];
    logic [SB_W-1:0]            sq_sb   [ROOT_W+1];

    // divider stages, index 0 holds the rounded numerators
    logic                       dv_v    [QUO_W+1];
    logic [2:0][SUM_W-1:0]      dv_rem  [QUO_W+1];
    logic [2:0][QUO_W-1:0]      dv_q    [QUO_W+1];
    logic [ROOT_W-1:0]          dv_s    [QUO_W+1];
    logic [2:0]                 dv_neg  [QUO_W+1];
    logic                       dv_zero [QUO_W+1];
    logic [SB_W-1:0]            dv_sb   [QUO_W+1];

    logic                       out_valid_reg;
    lav_pkg::qvec_t             out_vec_reg;
    logic [SB_W-1:0]            out_sb_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            sq_v[0] <= 1'b0;
            dv_v[0] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            sq_v[0] <= v4_reg;
            dv_v[0] <= sq_v[ROOT_W];
            out_valid_reg <= dv_v[QUO_W];
        end
    end

    always_comb
    begin
        logic [WIDE_W-1:0] orv;
        orv = mag0_reg[0] | mag0_reg[1] | mag0_reg[2];
        for (int g = 0; g < 8; g++)
        begin
            nz1_next[g]  = |orv[8*g +: 8];
            pos1_next[g] = 3'd0;
            for (int b = 0; b < 8; b++)
            begin
                if (orv[8*g + b])
                begin
                    pos1_next[g] = 3'(b);
                end
            end
        end
    end

    always_comb
    begin
        p2_next = 6'd0;
        for (int g = 0; g < 8; g++)
        begin
            if (nz1_reg[g])
            begin
                p2_next = {3'(g), pos1_reg[g]};
            end
        end
    end

    always_comb
    begin
        logic [WIDE_W-1:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            if (p2_reg >= 6'(lav_pkg::TOP_BIT))
            begin
                sh = mag2_reg[i] >> (p2_reg - 6'(lav_pkg::TOP_BIT));
            end
            else
            begin
                sh = mag2_reg[i] << (6'(lav_pkg::TOP_BIT) - p2_reg);
            end
            mag3_next[i] = sh[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg0_reg[i] <= in_vec[i][WIDE_W-1];
                mag0_reg[i] <= in_vec[i][WIDE_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
            end
            sb0_reg <= in_sb;

            neg1_reg <= neg0_reg;
            mag1_reg <= mag0_reg;
            sb1_reg  <= sb0_reg;
            nz1_reg  <= nz1_next;
            pos1_reg <= pos1_next;

            neg2_reg  <= neg1_reg;
            mag2_reg  <= mag1_reg;
            sb2_reg   <= sb1_reg;
            p2_reg    <= p2_next;
            zero2_reg <= ~|nz1_reg;

            neg3_reg  <= neg2_reg;
            mag3_reg  <= mag3_next;
            sb3_reg   <= sb2_reg;
            zero3_reg <= zero2_reg;

            neg4_reg  <= neg3_reg;
            mag4_reg  <= mag3_reg;
            sb4_reg   <= sb3_reg;
            zero4_reg <= zero3_reg;
            for (int i = 0; i < 3; i++)
            begin
                sqr4_reg[i] <= (2*MAG_W)'(mag3_reg[i]) * (2*MAG_W)'(mag3_reg[i]);
            end

            sq_rem[0]  <= SUM_W'(sqr4_reg[0]) + SUM_W'(sqr4_reg[1]) + SUM_W'(sqr4_reg[2]);
            sq_root[0] <= '0;
            sq_mag[0]  <= mag4_reg;
            sq_neg[0]  <= neg4_reg;
            sq_zero[0] <= zero4_reg;
            sq_sb[0]   <= sb4_reg;

            // numerator is mag * 2^30 plus half the root
            for (int i = 0; i < 3; i++)
            begin
                dv_rem[0][i] <= (SUM_W'(sq_mag[ROOT_W][i]) << lav_pkg::FRAC_W)
                              + SUM_W'(sq_root[ROOT_W] >> 1);
            end
            dv_q[0]    <= '0;
            dv_s[0]    <= sq_root[ROOT_W];
            dv_neg[0]  <= sq_neg[ROOT_W];
            dv_zero[0] <= sq_zero[ROOT_W];
            dv_sb[0]   <= sq_sb[ROOT_W];

            for (int i = 0; i < 3; i++)
            begin
                if (dv_zero[QUO_W])
                begin
                    out_vec_reg[i] <= '0;
                end
                else if (dv_neg[QUO_W][i])
                begin
                    out_vec_reg[i] <= -$signed({1'b0, dv_q[QUO_W][i]});
                end
                else
                begin
                    out_vec_reg[i] <= $signed({1'b0, dv_q[QUO_W][i]});
                end
            end
            out_sb_reg <= dv_sb[QUO_W];
        end
    end

    // one root bit per stage, remainder kept as n - root^2
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        localparam int B = ROOT_W - 1 - k;
        logic [WIDE_W-1:0] trial;
        assign trial = (WIDE_W'(sq_root[k]) << (B + 1)) | (WIDE_W'(1) << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_v[k+1] <= sq_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (WIDE_W'(sq_rem[k]) >= trial)
                begin
                    sq_rem[k+1]  <= sq_rem[k] - trial[SUM_W-1:0];
                    sq_root[k+1] <= sq_root[k] | (ROOT_W'(1) << B);
                end
                else
                begin
                    sq_rem[k+1]  <= sq_rem[k];
                    sq_root[k+1] <= sq_root[k];
                end
                sq_mag[k+1]  <= sq_mag[k];
                sq_neg[k+1]  <= sq_neg[k];
                sq_zero[k+1] <= sq_zero[k];
                sq_sb[k+1]   <= sq_sb[k];
            end
        end
    end

    // one quotient bit per stage for all three components
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        localparam int B = QUO_W - 1 - k;
        logic [SUM_W-1:0] dvs;
        assign dvs = SUM_W'(dv_s[k]) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_v[k+1] <= dv_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (dv_rem[k][i] >= dvs)
                    begin
                        dv_rem[k+1][i] <= dv_rem[k][i] - dvs;
                        dv_q[k+1][i]   <= dv_q[k][i] | (QUO_W'(1) << B);
                    end
                    else
                    begin
                        dv_rem[k+1][i] <= dv_rem[k][i];
                        dv_q[k+1][i]   <= dv_q[k][i];
                    end
                end
                dv_s[k+1]    <= dv_s[k];
                dv_neg[k+1]  <= dv_neg[k];
                dv_zero[k+1] <= dv_zero[k];
                dv_sb[k+1]   <= dv_sb[k];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vec   = out_vec_reg;
    assign out_sb    = out_sb_reg;

endmodule

@@ rtl/lav_cross.sv @@
// two-stage cross product a x b of 32-bit vectors, exact 64-bit result
// uses lav_pkg
module lav_cross #(
    parameter int SB_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  lav_pkg::qvec_t      in_a,
    input  lav_pkg::qvec_t      in_b,
    input  logic [SB_W-1:0]     in_sb,
    output logic                out_valid,
    output lav_pkg::wvec_t      out_vec,
    output logic [SB_W-1:0]     out_sb
);

    logic               v1_reg;
    lav_pkg::w_t        prod_reg [6];
    logic [SB_W-1:0]    sb1_reg;
    logic               v2_reg;
    lav_pkg::wvec_t     vec_reg;
    logic [SB_W-1:0]    sb2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= lav_pkg::w_t'(in_a[1]) * lav_pkg::w_t'(in_b[2]);
            prod_reg[1] <= lav_pkg::w_t'(in_a[2]) * lav_pkg::w_t'(in_b[1]);
            prod_reg[2] <= lav_pkg::w_t'(in_a[2]) * lav_pkg::w_t'(in_b[0]);
            prod_reg[3] <= lav_pkg::w_t'(in_a[0]) * lav_pkg::w_t'(in_b[2]);
            prod_reg[4] <= lav_pkg::w_t'(in_a[0]) * lav_pkg::w_t'(in_b[1]);
            prod_reg[5] <= lav_pkg::w_t'(in_a[1]) * lav_pkg::w_t'(in_b[0]);
            sb1_reg <= in_sb;
            vec_reg[0] <= prod_reg[0] - prod_reg[1];
            vec_reg[1] <= prod_reg[2] - prod_reg[3];
            vec_reg[2] <= prod_reg[4] - prod_reg[5];
            sb2_reg <= sb1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_vec   = vec_reg;
    assign out_sb    = sb2_reg;

endmodule

@@ rtl/lav_dot.sv @@
// three-stage translation terms: -(eye . axis), rounded to q16.16 and saturated
// uses lav_pkg; the last stage doubles as the output register
module lav_dot (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  lav_pkg::qvec_t      in_eye,
    input  lav_pkg::qmat_t      in_axes,
    output logic                out_valid,
    output lav_pkg::qmat_t      out_axes,
    output lav_pkg::qvec_t      out_shift
);

    localparam int T_W = lav_pkg::WIDE_W + 1;

    logic               v1_reg;
    lav_pkg::w_t        prod_reg [3][3];
    lav_pkg::qmat_t     axes1_reg;
    logic               v2_reg;
    lav_pkg::wvec_t     sum_reg;
    lav_pkg::qmat_t     axes2_reg;
    logic               v3_reg;
    lav_pkg::qvec_t     shift_reg;
    lav_pkg::qmat_t     axes3_reg;
    lav_pkg::qvec_t     shift_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // negate, add half, floor-shift by 30, clamp
    always_comb
    begin
        logic signed [T_W-1:0] t;
        logic signed [T_W-1:0] r;
        for (int a = 0; a < 3; a++)
        begin
            t = -$signed({sum_reg[a][lav_pkg::WIDE_W-1], sum_reg[a]})
              + (T_W'(1) <<< (lav_pkg::FRAC_W - 1));
            r = t >>> lav_pkg::FRAC_W;
            if (r > $signed(T_W'(32'h7fff_ffff)))
            begin
                shift_next[a] = 32'sh7fff_ffff;
            end
            else if (r < -$signed(T_W'(33'h0_8000_0000)))
            begin
                shift_next[a] = 32'sh8000_0000;
            end
            else
            begin
                shift_next[a] = r[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[a][c] <= lav_pkg::w_t'(in_eye[c]) * lav_pkg::w_t'(in_axes[a][c]);
                end
                sum_reg[a] <= prod_reg[a][0] + prod_reg[a][1] + prod_reg[a][2];
            end
            axes1_reg <= in_axes;
            axes2_reg <= axes1_reg;
            axes3_reg <= axes2_reg;
            shift_reg <= shift_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_axes  = axes3_reg;
    assign out_shift = shift_reg;

endmodule

@@ rtl/look_at_view_matrix_core.sv @@
// look_at_view_matrix_core: each input item passes the difference stage, three
// normalizers, two cross products and the dot stage on its way to a result item
// one item per cycle unless stalled; square root and dividers fully pipelined
// the whole pipeline moves together and holds while a result waits at the output
// rst_n is asynchronous: clears all valid bits, up vector returns to (0, 1.0, 0)
module look_at_view_matrix_core (
    input  logic            clk,
    input  logic            rst_n,
    // input items
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // eye_x, eye_y, eye_z, look_x, look_y, look_z, 32 bits each from bit 0
    input  logic [191:0]    s_axis_tdata,
    // result items
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // right_x/y/z, upward_x/y/z, back_x/y/z, shift_x/y/z, 32 bits each from bit 0
    output logic [383:0]    m_axis_tdata,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lav_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int EYE_W = 3 * lav_pkg::AXIS_W;

    // up vector registers
    logic [31:0]        up_x_reg;
    logic [31:0]        up_y_reg;
    logic [31:0]        up_z_reg;
    lav_pkg::qvec_t     up_vec;

    // global advance: every stage moves when the output is free or being taken
    logic               en;

    // difference stage
    logic               d_valid_reg;
    lav_pkg::wvec_t     dir_reg;
    lav_pkg::qvec_t     eye_reg;
    lav_pkg::qvec_t     in_eye;
    lav_pkg::qvec_t     in_look;

    // back axis
    logic               n1_valid;
    lav_pkg::qvec_t     back_vec;
    logic [EYE_W-1:0]   n1_sb;

    // up x back
    logic               c1_valid;
    lav_pkg::wvec_t     c1_vec;
    logic [2*EYE_W-1:0] c1_sb;

    // right axis, sideband holds eye and back
    logic               n2_valid;
    lav_pkg::qvec_t     right_vec;
    logic [2*EYE_W-1:0] n2_sb;

    // back x right
    logic               c2_valid;
    lav_pkg::wvec_t     c2_vec;
    logic [3*EYE_W-1:0] c2_sb;

    // upward axis, sideband holds eye, back and right
    logic               n3_valid;
    lav_pkg::qvec_t     upward_vec;
    logic [3*EYE_W-1:0] n3_sb;

    lav_pkg::qmat_t     axes;
    lav_pkg::qmat_t     out_axes;
    lav_pkg::qvec_t     out_shift;

    logic               cfg_write;

    // apb register file, zero wait state
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_x_reg <= lav_pkg::UP_X_RST;
            up_y_reg <= lav_pkg::UP_Y_RST;
            up_z_reg <= lav_pkg::UP_Z_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                lav_pkg::REG_UP_X: up_x_reg <= pwdata;
                lav_pkg::REG_UP_Y: up_y_reg <= pwdata;
                lav_pkg::REG_UP_Z: up_z_reg <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            lav_pkg::REG_UP_X: prdata = up_x_reg;
            lav_pkg::REG_UP_Y: prdata = up_y_reg;
            lav_pkg::REG_UP_Z: prdata = up_z_reg;
            default:           prdata = '0;
        endcase
    end

    assign up_vec[0] = up_x_reg;
    assign up_vec[1] = up_y_reg;
    assign up_vec[2] = up_z_reg;

    assign en            = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = en;

    // unpack the input item
    for (genvar i = 0; i < 3; i++)
    begin : g_unpack
        assign in_eye[i]  = s_axis_tdata[32*i +: 32];
        assign in_look[i] = s_axis_tdata[32*(i+3) +: 32];
    end

    // eye minus target, sign extended to the wide format
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dir_reg[i] <= lav_pkg::w_t'(in_eye[i]) - lav_pkg::w_t'(in_look[i]);
            end
            eye_reg <= in_eye;
        end
    end

    lav_norm #(.SB_W(EYE_W)) u_norm_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid_reg),
        .in_vec    (dir_reg),
        .in_sb     (eye_reg),
        .out_valid (n1_valid),
        .out_vec   (back_vec),
        .out_sb    (n1_sb)
    );

    lav_cross #(.SB_W(2*EYE_W)) u_cross_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n1_valid),
        .in_a      (up_vec),
        .in_b      (back_vec),
        .in_sb     ({back_vec, n1_sb}),
        .out_valid (c1_valid),
        .out_vec   (c1_vec),
        .out_sb    (c1_sb)
    );

    lav_norm #(.SB_W(2*EYE_W)) u_norm_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c1_valid),
        .in_vec    (c1_vec),
        .in_sb     (c1_sb),
        .out_valid (n2_valid),
        .out_vec   (right_vec),
        .out_sb    (n2_sb)
    );

    lav_cross #(.SB_W(3*EYE_W)) u_cross_upward (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n2_valid),
        .in_a      (n2_sb[2*EYE_W-1:EYE_W]),
        .in_b      (right_vec),
        .in_sb     ({right_vec, n2_sb}),
        .out_valid (c2_valid),
        .out_vec   (c2_vec),
        .out_sb    (c2_sb)
    );

    lav_norm #(.SB_W(3*EYE_W)) u_norm_upward (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c2_valid),
        .in_vec    (c2_vec),
        .in_sb     (c2_sb),
        .out_valid (n3_valid),
        .out_vec   (upward_vec),
        .out_sb    (n3_sb)
    );

    assign axes[0] = n3_sb[3*EYE_W-1:2*EYE_W];
    assign axes[1] = upward_vec;
    assign axes[2] = n3_sb[2*EYE_W-1:EYE_W];

    lav_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n3_valid),
        .in_eye    (n3_sb[EYE_W-1:0]),
        .in_axes   (axes),
        .out_valid (m_axis_tvalid),
        .out_axes  (out_axes),
        .out_shift (out_shift)
    );

    // pack the result item
    for (genvar a = 0; a < 3; a++)
    begin : g_pack
        for (genvar c = 0; c < 3; c++)
        begin : g_comp
            assign m_axis_tdata[32*(3*a+c) +: 32] = out_axes[a][c];
        end
        assign m_axis_tdata[32*(9+a) +: 32] = out_shift[a];
    end

    // back_x and right_y never leave [-1.0, 1.0] in q2.30
    a_back_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(out_axes[2][0]) <= 32'sh4000_0000)
                       && ($signed(out_axes[2][0]) >= -32'sh4000_0000))
        else $error("back_x out of range");

    a_right_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(out_axes[0][1]) <= 32'sh4000_0000)
                       && ($signed(out_axes[0][1]) >= -32'sh4000_0000))
        else $error("right_y out of range");

    // eye on the target gives no right axis
    a_zero_back: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_axes[2] == '0) |-> (out_axes[0] == '0))
        else $error("right axis not zero for zero back axis");

    // no right axis gives no upward axis
    a_zero_right: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_axes[0] == '0) |-> (out_axes[1] == '0))
        else $error("upward axis not zero for zero right axis");

endmodule

@@ test/look_at_view_matrix_core_tb.sv @@
// testbench for look_at_view_matrix_core: random and directed eye/target items
// with an independent fixed-point predictor and an in-order scoreboard class
// depends on rtl/lav_pkg.sv, rtl/look_at_view_matrix_core.sv and its submodules
`timescale 1ns / 100ps

module look_at_view_matrix_core_tb;
    import lav_pkg::*;

    localparam int LATENCY   = 218;
    localparam int NUM_RAND  = 500;
    localparam int CYCLE_MAX = 400000;

    typedef logic [31:0] word_t;
    typedef word_t [11:0] view_t;            // right, upward, back, shift

    // predictor of the view matrix, keeps its own copy of the up vector
    class view_scoreboard;
        w_t up_vec [3];
        view_t pending [$];
        int mismatches;

        function new();
            up_vec[0] = w_t'(q_t'(UP_X_RST));
            up_vec[1] = w_t'(q_t'(UP_Y_RST));
            up_vec[2] = w_t'(q_t'(UP_Z_RST));
            mismatches = 0;
        endfunction

        function void set_up(int idx, word_t val);
            if (idx < 3)
                up_vec[idx] = w_t'(q_t'(val));
        endfunction

        static function logic [63:0] floor_root(logic [63:0] n);
            logic [63:0] res;
            logic [63:0] bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // scale the largest magnitude into [2^29, 2^30), then divide by the root
        static function void unit_vec(input w_t v [3], output w_t o [3]);
            logic [63:0] mag [3];
            logic [63:0] m, sum, s, q;
            bit neg [3];
            m = 0;
            for (int i = 0; i < 3; i++)
            begin
                neg[i] = v[i] < 0;
                mag[i] = neg[i] ? -v[i] : v[i];
                if (mag[i] > m)
                    m = mag[i];
            end
            if (m == 0)
            begin
                for (int i = 0; i < 3; i++)
                    o[i] = 0;
                return;
            end
            while (m >= 64'h4000_0000)
            begin
                m = m >> 1;
                for (int i = 0; i < 3; i++)
                    mag[i] = mag[i] >> 1;
            end
            while (m < 64'h2000_0000)
            begin
                m = m << 1;
                for (int i = 0; i < 3; i++)
                    mag[i] = mag[i] << 1;
            end
            sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            s = floor_root(sum);
            for (int i = 0; i < 3; i++)
            begin
                q = ((mag[i] << 30) + (s >> 1)) / s;
                o[i] = neg[i] ? -w_t'(q) : w_t'(q);
            end
        endfunction

        static function void cross_prod(input w_t a [3], input w_t b [3], output w_t o [3]);
            o[0] = a[1] * b[2] - a[2] * b[1];
            o[1] = a[2] * b[0] - a[0] * b[2];
            o[2] = a[0] * b[1] - a[1] * b[0];
        endfunction

        // negated dot product, rounded to q16.16 and saturated
        static function word_t translation(w_t eye [3], w_t ax [3]);
            w_t t, r;
            t = -(eye[0] * ax[0] + eye[1] * ax[1] + eye[2] * ax[2]) + 64'sh2000_0000;
            r = t >>> 30;                    // arithmetic shift is floor
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            return r[31:0];
        endfunction

        function void note_item(logic [191:0] data);
            w_t eye [3], dir [3], tmp [3], bk [3], rt [3], uw [3];
            view_t res;
            for (int i = 0; i < 3; i++)
            begin
                eye[i] = w_t'(q_t'(data[32*i +: 32]));
                dir[i] = eye[i] - w_t'(q_t'(data[32*(i+3) +: 32]));
            end
            unit_vec(dir, bk);
            cross_prod(up_vec, bk, tmp);
            unit_vec(tmp, rt);
            cross_prod(bk, rt, tmp);
            unit_vec(tmp, uw);
            for (int i = 0; i < 3; i++)
            begin
                res[i]     = rt[i][31:0];
                res[3 + i] = uw[i][31:0];
                res[6 + i] = bk[i][31:0];
            end
            res[9]  = translation(eye, rt);
            res[10] = translation(eye, uw);
            res[11] = translation(eye, bk);
            pending.push_back(res);
        endfunction

        function void check_result(logic [383:0] data);
            view_t exp_v;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", data);
                return;
            end
            exp_v = pending.pop_front();
            for (int f = 0; f < 12; f++)
                if (data[32*f +: 32] !== exp_v[f])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("field %0d: expected %h got %h", f, exp_v[f],
                                 data[32*f +: 32]);
                end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;     // eye_x, eye_y, eye_z, look_x, look_y, look_z
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [383:0] m_axis_tdata;     // right xyz, upward xyz, back xyz, shift xyz
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    view_scoreboard board;
    int  cycle_count;
    bit  hold_results;              // long receiver hold-off window
    bit  steady;                    // stretch with no idling on either side

    look_at_view_matrix_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        board = new();
        cycle_count = 0;
        hold_results = 0;
        steady = 0;
    end

    // timeout guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_MAX)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stalls unless steady, never ready while held
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            m_axis_tready <= !hold_results && (steady || $urandom_range(99) >= 12);
        end
    end

    // an apb register write, setup then access phase, only with the pipeline empty
    task automatic write_up(int idx, word_t val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.set_up(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offer one item, with a random gap first, and wait for acceptance
    // tvalid stays high after acceptance so items can follow back to back
    task automatic send_view(logic [191:0] data);
        while (!steady && $urandom_range(99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_item(data);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic word_t rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return word_t'($signed($urandom_range(2000)) - 1000) << 16;
            2: return word_t'($signed($urandom_range(200)) - 100);
            3: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return word_t'($signed($urandom_range(1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic logic [191:0] rand_view();
        logic [191:0] d;
        for (int i = 0; i < 6; i++)
            d[32*i +: 32] = rand_coord();
        // sometimes look equals eye or lies along one axis from it
        case ($urandom_range(9))
            0: d[191:96] = d[95:0];
            1:
            begin
                d[191:96] = d[95:0];
                d[32*($urandom_range(2) + 3) +: 32] = rand_coord();
            end
            default: ;
        endcase
        return d;
    endfunction

    task automatic send_coords(word_t ex, word_t ey, word_t ez,
                               word_t lx, word_t ly, word_t lz);
        send_view({lz, ly, lx, ez, ey, ex});
    endtask

    // up vector settings, extremes among them
    word_t up_sets [6][3] = '{
        '{32'h0000_0000, 32'h0001_0000, 32'h0000_0000},
        '{32'h0001_0000, 32'h0000_0000, 32'h0000_0000},
        '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},
        '{32'h8000_0000, 32'h0000_0001, 32'hffff_ffff},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{32'h0000_0000, 32'h0000_0000, 32'hfffe_0000}
    };

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default up vector
        send_coords(0, 0, 0, 0, 0, 0);                      // eye equals target
        send_coords(0, 0, 32'h0005_0000, 0, 0, 0);          // looking down -z
        send_coords(0, 32'h0003_0000, 0, 0, 0, 0);          // up parallel to view
        send_coords(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_coords(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                    32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_coords(32'h8000_0000, 0, 32'h7fff_ffff, 0, 32'h0000_0001, 0);
        send_coords(1, 0, 0, 0, 0, 0);                      // smallest direction
        send_coords(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0);
        send_coords(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h7fff_fffe, 32'h7fff_ffff, 32'h7fff_ffff);
        send_coords(32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f,
                    32'hedcb_a987, 32'h6543_2100, 32'hf0f0_f0f0);
        wait_drained();

        // random phases across up vector settings
        for (int p = 0; p < 6; p++)
        begin
            for (int r = 0; r < 3; r++)
                write_up(r, up_sets[p][r]);
            if (p == 2)
            begin
                write_up(0, $urandom());
                write_up(1, $urandom());
                write_up(2, $urandom());
            end
            steady = (p == 1);
            if (p == 3)
                fork
                    begin
                        hold_results = 1;
                        repeat (LATENCY * 3) @(posedge clk);
                        hold_results = 0;
                    end
                join_none
            for (int n = 0; n < NUM_RAND / 6; n++)
            begin
                send_view(rand_view());
                if (p == 3)
                begin
                    // spread items out so the sender is still offering when
                    // the held output stalls the pipeline
                    s_axis_tvalid <= 1'b0;
                    repeat (3) @(posedge clk);
                end
                if (p == 4 && n == 40)
                begin
                    // sender pause until everything is back
                    s_axis_tvalid <= 1'b0;
                    while (board.pending.size() != 0)
                        @(posedge clk);
                end
            end
            steady = 0;
            wait_drained();
        end

        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
